// ===== sv/okpc_pkg.sv =====
`timescale 1ns / 1ps

package okpc_pkg;

  // In-buffer index width; byte_index carries its low 32 bits
  localparam int IndexBits = 32;

  // Mixing constants
  localparam logic [63:0] GoldenInc = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MixMulA   = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MixMulB   = 64'h94D049BB133111EB;
  localparam logic [63:0] PosMul    = 64'h00000100000001B3;

  // Configuration register indexes
  localparam logic [1:0] RegSeed        = 2'd0;
  localparam logic [1:0] RegStartOffset = 2'd1;
  localparam logic [1:0] RegVerifyMode  = 2'd2;

  // Request to the shared multiplier
  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_M1   = 5'b00010,
    S_M2   = 5'b00100,
    S_M3   = 5'b01000,
    S_FIN  = 5'b10000
  } seq_state_t;

endpackage

// ===== sv/offset_keyed_pattern_checker.sv =====
`timescale 1ns / 1ps

// Storage test pattern generator and checker. Each aligned 8-byte word at
// absolute byte position p is splitmix64(seed ^ (p * 0x100000001B3)), sent
// little-endian. One byte is taken per transfer and gives one result: the
// expected byte, its mismatch flags in verify mode, its index in the buffer
// and, on the last byte, whether the buffer passed. Every byte recomputes its
// word through three 64-bit multiplies on one shared 32x32 multiplier. Each
// multiply hands its product to the mixing logic for the next step, and
// S_FIN then loads the result into the output register. A new byte is taken
// only once the sequencer is back in idle, so a byte is finished before the
// next one is accepted. The result waits in an output register, so the next
// byte can be taken before it leaves. Configure only while the block is
// idle; a start_offset write between buffers also loads the current position.
module offset_keyed_pattern_checker import okpc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_of_buffer,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  pattern_byte,
  output logic        mismatch,
  output logic        first_mismatch,
  output logic [31:0] byte_index,
  output logic        buffer_passed
);

  logic [63:0]          seed;
  logic [63:0]          start_offset;
  logic                 verify_mode;
  logic [63:0]          position;
  logic [IndexBits-1:0] index_in_buffer;
  logic                 mismatch_seen;
  logic [7:0]           data_r;
  logic                 last_r;
  seq_state_t           state;
  seq_state_t           state_next;
  mul_req_t             mul_req;
  logic                 mul_done;
  logic [63:0]          mul_product;
  logic [63:0]          mix_a;
  logic [63:0]          mix_b;
  logic [63:0]          word;
  logic [7:0]           expect_byte;
  logic                 miss;
  logic                 in_xfer;
  logic                 out_free;

  assign in_xfer  = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  okpc_mul64 u_mul (
    .clk     (clk),
    .rst     (rst),
    .req     (mul_req),
    .done    (mul_done),
    .product (mul_product)
  );

  // Mixing steps between multiplies
  always_comb begin
    mix_a = (seed ^ mul_product) + GoldenInc;
    mix_a = mix_a ^ (mix_a >> 30);
    mix_b = mul_product ^ (mul_product >> 27);
    word  = mul_product ^ (mul_product >> 31);
  end

  // Select the lane and compare
  always_comb begin
    expect_byte = 8'(word >> {position[2:0], 3'b000});
    miss        = verify_mode && (data_r != expect_byte);
  end

  // Sequence the three multiplies
  always_comb begin
    state_next    = state;
    mul_req.start = 1'b0;
    mul_req.a     = mix_a;
    mul_req.b     = MixMulA;
    case (state)
      S_IDLE: begin
        mul_req.a = {position[63:3], 3'b000};
        mul_req.b = PosMul;
        if (in_xfer) begin
          mul_req.start = 1'b1;
          state_next    = S_M1;
        end
      end
      S_M1: begin
        if (mul_done) begin
          mul_req.start = 1'b1;
          state_next    = S_M2;
        end
      end
      S_M2: begin
        mul_req.a = mix_b;
        mul_req.b = MixMulB;
        if (mul_done) begin
          mul_req.start = 1'b1;
          state_next    = S_M3;
        end
      end
      S_M3: begin
        if (mul_done) state_next = S_FIN;
      end
      S_FIN: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control state, registers and buffer tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      seed            <= '0;
      start_offset    <= '0;
      verify_mode     <= 1'b0;
      position        <= '0;
      index_in_buffer <= '0;
      mismatch_seen   <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          RegSeed:        seed <= cfg_data;
          RegStartOffset: begin
            start_offset <= cfg_data;
            if (index_in_buffer == '0) position <= cfg_data;
          end
          RegVerifyMode:  verify_mode <= cfg_data[0];
          default:        ;
        endcase
      end
      if (state == S_FIN && out_free) begin
        out_valid <= 1'b1;
        if (last_r) begin
          position        <= start_offset;
          index_in_buffer <= '0;
          mismatch_seen   <= 1'b0;
        end else begin
          position      <= position + 64'd1;
          mismatch_seen <= mismatch_seen || miss;
          if (index_in_buffer != '1) index_in_buffer <= index_in_buffer + 1'b1;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the accepted byte and load the result
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      data_r <= data_byte;
      last_r <= last_of_buffer;
    end
    if (state == S_FIN && out_free) begin
      pattern_byte   <= expect_byte;
      mismatch       <= miss;
      first_mismatch <= miss && !mismatch_seen;
      byte_index     <= 32'(index_in_buffer);
      buffer_passed  <= last_r && !(mismatch_seen || miss);
    end
  end

  a_accept_starts_mul: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> (state == S_M1))
    else $error("accepted byte did not start the multiply sequence");

  a_first_implies_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!first_mismatch || mismatch))
    else $error("first_mismatch without mismatch");

  a_pass_no_miss: assert property (@(posedge clk) disable iff (rst)
    (out_valid && buffer_passed) |-> !mismatch)
    else $error("buffer passed on a mismatching byte");

  a_done_when_waiting: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == S_M1 || state == S_M2 || state == S_M3))
    else $error("multiplier finished outside a multiply state");

endmodule

// ===== sv/okpc_mul64.sv =====
`timescale 1ns / 1ps

// Low 64 bits of a 64x64 product from three 32x32 partial products,
// one partial product per cycle, each registered and summed in the cycle after.
module okpc_mul64 import okpc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  mul_req_t    req,
  output logic        done,
  output logic [63:0] product
);

  logic [63:0] a_r;
  logic [63:0] b_r;
  logic        busy;
  logic [1:0]  step;
  logic [63:0] prod_r;
  logic [31:0] op_a;
  logic [31:0] op_b;

  // Pick the halves for this step: lo*lo, lo*hi, hi*lo
  always_comb begin
    op_a = (step == 2'd2) ? a_r[63:32] : a_r[31:0];
    op_b = (step == 2'd1) ? b_r[63:32] : b_r[31:0];
  end

  // Advance the step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= 2'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= 2'd0;
      end else if (busy) begin
        step <= step + 2'd1;
        if (step == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Multiply, then accumulate the registered partial product
  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r <= req.a;
      b_r <= req.b;
    end
    if (busy) begin
      prod_r <= 64'(op_a) * 64'(op_b);
      case (step)
        2'd1:    product <= prod_r;
        2'd2,
        2'd3:    product[63:32] <= product[63:32] + prod_r[31:0];
        default: product <= product;
      endcase
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import okpc_pkg::*;

  localparam int CycleLimit = 1_000_000;
  localparam int LongHold = 300;
  localparam int RandomItems = 1300;
  localparam logic [1:0] RegUnused = 2'd3;
  localparam logic [63:0] AllOnes = {64{1'b1}};

  typedef struct {
    logic [7:0] data;
    logic       last;
  } read_byte_t;

  typedef struct {
    logic [7:0]  pattern;
    logic        miss;
    logic        first;
    logic [31:0] index;
    logic        passed;
  } byte_verdict_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = RegSeed;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = '0;
  logic        last_of_buffer = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  pattern_byte;
  logic        mismatch;
  logic        first_mismatch;
  logic [31:0] byte_index;
  logic        buffer_passed;

  // Predictor copy of the registers and the running buffer state
  logic [63:0]          seed_reg = '0;
  logic [63:0]          offset_reg = '0;
  logic                 verify_reg = 1'b0;
  logic [63:0]          pat_pos = '0;
  logic [IndexBits-1:0] buf_index = '0;
  logic                 buf_has_miss = 1'b0;

  // Position the stimulus generator expects for the next byte it queues
  logic [63:0] plan_pos = '0;

  read_byte_t    read_bytes_q[$];
  byte_verdict_t verdicts_q[$];
  byte_verdict_t fresh;
  byte_verdict_t oldest;
  read_byte_t    next_byte;

  int  items_queued = 0;
  int  results_seen = 0;
  int  error_count = 0;
  int  cycle_count = 0;
  bit  in_taken = 1'b0;
  int  tx_gap = 0;
  bit  tx_calm = 1'b0;
  int  rx_stall_left = 0;
  bit  rx_calm = 1'b0;
  bit  long_hold_req = 1'b0;
  bit  long_hold_taken = 1'b0;

  offset_keyed_pattern_checker DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .last_of_buffer (last_of_buffer),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .pattern_byte   (pattern_byte),
    .mismatch       (mismatch),
    .first_mismatch (first_mismatch),
    .byte_index     (byte_index),
    .buffer_passed  (buffer_passed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // splitmix64 finalizer
  function automatic logic [63:0] mix_word(input logic [63:0] v);
    logic [63:0] x;
    x = v + GoldenInc;
    x = (x ^ (x >> 30)) * MixMulA;
    x = (x ^ (x >> 27)) * MixMulB;
    return x ^ (x >> 31);
  endfunction

  // Byte at absolute position p: lane p[2:0] of the word keyed by the aligned base
  function automatic logic [7:0] pattern_at(input logic [63:0] sd, input logic [63:0] p);
    logic [63:0] word;
    word = mix_word(sd ^ ({p[63:3], 3'b000} * PosMul));
    return 8'(word >> {p[2:0], 3'b000});
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 16);
    return $urandom_range(20, 60);
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endtask

  // Write one register while idle and mirror it in the predictor
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      RegSeed: seed_reg = value;
      RegStartOffset: begin
        offset_reg = value;
        if (buf_index == '0) pat_pos = value;
      end
      RegVerifyMode: verify_reg = value[0];
      default: ;
    endcase
    plan_pos = pat_pos;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_item(input logic [7:0] d, input logic close);
    read_byte_t rb;
    rb.data = d;
    rb.last = close;
    read_bytes_q.push_back(rb);
    items_queued++;
  endtask

  // Queue the correct byte for the planned position, optionally corrupted
  task automatic push_planned(input bit err, input bit close);
    logic [7:0] d;
    if (verify_reg) d = pattern_at(seed_reg, plan_pos);
    else d = 8'($urandom_range(0, 255));
    if (err) d = d ^ 8'($urandom_range(1, 255));
    push_item(d, close);
    plan_pos = close ? offset_reg : plan_pos + 64'd1;
  endtask

  task automatic queue_buffer(input int len, input int err_pct, input bit close);
    for (int k = 0; k < len; k++) begin
      push_planned($urandom_range(0, 99) < err_pct, close && (k == len - 1));
    end
  endtask

  task automatic wait_idle();
    while (results_seen < items_queued) @(negedge clk);
  endtask

  // Driver: hold a stalled transfer, otherwise idle or launch the next byte
  always @(negedge clk) begin
    if (in_valid && !in_taken) begin
      // hold
    end else if (tx_gap > 0) begin
      in_valid <= 1'b0;
      tx_gap = tx_gap - 1;
    end else if (read_bytes_q.size() > 0) begin
      next_byte = read_bytes_q.pop_front();
      data_byte <= next_byte.data;
      last_of_buffer <= next_byte.last;
      in_valid <= 1'b1;
      if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
      tx_gap = tx_calm ? 0 : pick_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: random stalls, calm stretches, and one long hold on request
  always @(negedge clk) begin
    if (long_hold_req && !long_hold_taken) begin
      long_hold_taken = 1'b1;
      rx_stall_left = LongHold;
    end
    if ($urandom_range(0, 299) == 0) rx_calm = !rx_calm;
    if (rx_stall_left > 0) begin
      out_stall <= 1'b1;
      rx_stall_left = rx_stall_left - 1;
    end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      rx_stall_left = pick_gap();
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: predict on each input transfer, check each output transfer
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      in_taken = in_valid && !in_stall;
      if (in_taken) begin
        fresh.pattern = pattern_at(seed_reg, pat_pos);
        fresh.miss = verify_reg && (data_byte != fresh.pattern);
        fresh.first = fresh.miss && !buf_has_miss;
        fresh.index = buf_index[31:0];
        fresh.passed = last_of_buffer && !(buf_has_miss || fresh.miss);
        verdicts_q.push_back(fresh);
        if (last_of_buffer) begin
          pat_pos = offset_reg;
          buf_index = '0;
          buf_has_miss = 1'b0;
        end else begin
          pat_pos = pat_pos + 64'd1;
          if (buf_index != '1) buf_index = buf_index + 1'b1;
          buf_has_miss = buf_has_miss || fresh.miss;
        end
      end
      if (!rst && out_valid && !out_stall) begin
        results_seen++;
        if (verdicts_q.size() == 0) begin
          error_count++;
          $display("%0t: result with none pending, pattern_byte %02h index %0d",
                   $time, pattern_byte, byte_index);
        end else begin
          oldest = verdicts_q.pop_front();
          check_field("pattern_byte", 64'(oldest.pattern), 64'(pattern_byte));
          check_field("mismatch", 64'(oldest.miss), 64'(mismatch));
          check_field("first_mismatch", 64'(oldest.first), 64'(first_mismatch));
          check_field("byte_index", 64'(oldest.index), 64'(byte_index));
          check_field("buffer_passed", 64'(oldest.passed), 64'(buffer_passed));
        end
      end
    end
  end

  // Stimulus: directed cases, then random phases with register changes between them
  initial begin
    int phase;
    int r;
    int len;
    int errp;
    int nbuf;
    logic [63:0] v;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Generate mode straight out of reset, data extremes
    push_item(8'h00, 1'b0);
    push_item(8'hFF, 1'b0);
    push_item(8'hA5, 1'b1);
    wait_idle();

    // Unknown index is ignored; offset written between buffers loads position
    write_reg(RegUnused, AllOnes);
    write_reg(RegSeed, AllOnes);
    write_reg(RegVerifyMode, AllOnes);
    write_reg(RegStartOffset, 64'hFFFF_FFFF_FFFF_FFFA);
    // Clean buffer across the position wrap
    queue_buffer(10, 0, 1'b1);
    wait_idle();

    // Several mismatches, the last byte wrong too
    push_planned(1'b0, 1'b0);
    push_planned(1'b1, 1'b0);
    push_planned(1'b0, 1'b0);
    push_planned(1'b1, 1'b0);
    push_planned(1'b1, 1'b1);
    // Only the last byte wrong
    push_planned(1'b0, 1'b0);
    push_planned(1'b1, 1'b1);
    // Open buffer carrying a mismatch
    push_planned(1'b1, 1'b0);
    push_planned(1'b0, 1'b0);
    wait_idle();

    // Mid-buffer changes: offset waits for the next buffer, seed and mode apply now
    write_reg(RegSeed, 64'd0);
    write_reg(RegStartOffset, 64'd0);
    write_reg(RegVerifyMode, 64'hFFFF_FFFF_FFFF_FFFE);
    push_planned(1'b1, 1'b0);
    push_planned(1'b0, 1'b1);
    wait_idle();

    // Random phases
    phase = 0;
    while (items_queued < RandomItems + 24) begin
      wait_idle();
      if ($urandom_range(0, 1) == 1) begin
        r = $urandom_range(0, 3);
        v = (r == 0) ? 64'd0 : (r == 1) ? AllOnes : {$urandom, $urandom};
        write_reg(RegSeed, v);
      end
      if ($urandom_range(0, 1) == 1) begin
        r = $urandom_range(0, 4);
        case (r)
          0: v = 64'd0;
          1: v = AllOnes;
          2: v = AllOnes - 64'($urandom_range(0, 16));
          3: v = 64'($urandom_range(0, 1000));
          default: v = {$urandom, $urandom};
        endcase
        write_reg(RegStartOffset, v);
      end
      if ($urandom_range(0, 2) != 0) write_reg(RegVerifyMode, {$urandom, $urandom});
      if ($urandom_range(0, 15) == 0) write_reg(RegUnused, {$urandom, $urandom});

      // Hold the output side long enough for the block to back up its input
      if (phase == 2) begin
        long_hold_req = 1'b1;
        queue_buffer(40, 0, 1'b1);
      end

      nbuf = $urandom_range(1, 6);
      for (int b = 0; b < nbuf; b++) begin
        r = $urandom_range(0, 99);
        if (r < 80) len = $urandom_range(1, 24);
        else if (r < 95) len = $urandom_range(25, 64);
        else len = $urandom_range(65, 200);
        r = $urandom_range(0, 99);
        errp = (r < 65) ? 0 : (r < 90) ? 5 : 60;
        queue_buffer(len, errp, !(b == nbuf - 1 && $urandom_range(0, 4) == 0));
      end
      phase++;
    end

    // Drain, then allow for the block's latency
    wait_idle();
    repeat (40) @(negedge clk);
    if (error_count == 0 && verdicts_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/okpc_pkg.sv
sv/okpc_mul64.sv
sv/offset_keyed_pattern_checker.sv
tb/testbench.sv
